// ===== rtl/csa_pkg.sv =====
// Shared types and constants for the compacting segment allocator.
package csa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef logic [15:0] word_t;

  localparam word_t TOTAL_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef struct packed {
    word_t owner;
    word_t length;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/csa_ram.sv =====
// Simple dual-port segment table memory with registered read data.
module csa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/csa_ctrl.sv =====
// Request sequencer: decodes requests, walks and compacts the segment table.
module csa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [15:0]          in_proc_id,
  input  logic [15:0]          in_req_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [15:0]          out_base_addr,
  output logic [15:0]          out_free_space,
  output logic                 out_compacted,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata,
  output csa_pkg::mem_req_t    mem_req,
  input  csa_pkg::seg_entry_t  mem_rdata
);

  import csa_pkg::*;

  state_t           state_r, state_nxt;
  word_t            total_r, total_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  word_t            used_r, used_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  word_t            acc_r, acc_nxt;
  logic [1:0]       kind_r, kind_nxt;
  word_t            owner_r, owner_nxt;
  word_t            size_r, size_nxt;
  status_t          res_status_r, res_status_nxt;
  word_t            res_base_r, res_base_nxt;
  logic             res_moved_r, res_moved_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  word_t            out_base_r, out_base_nxt;
  word_t            out_free_r, out_free_nxt;
  logic             out_moved_r, out_moved_nxt;
  word_t            space_w;
  logic [CNT_W:0]   idx_p1_w;
  logic [CNT_W:0]   idx_p2_w;

  assign space_w  = (total_r > used_r) ? (total_r - used_r) : '0;
  assign idx_p1_w = (CNT_W + 1)'(idx_r) + (CNT_W + 1)'(1);
  assign idx_p2_w = (CNT_W + 1)'(idx_r) + (CNT_W + 1)'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= TOTAL_RESET;
      count_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    acc_r        <= acc_nxt;
    kind_r       <= kind_nxt;
    owner_r      <= owner_nxt;
    size_r       <= size_nxt;
    res_status_r <= res_status_nxt;
    res_base_r   <= res_base_nxt;
    res_moved_r  <= res_moved_nxt;
    out_status_r <= out_status_nxt;
    out_base_r   <= out_base_nxt;
    out_free_r   <= out_free_nxt;
    out_moved_r  <= out_moved_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = cfg_we ? cfg_wdata : total_r;
    count_nxt      = count_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    acc_nxt        = acc_r;
    kind_nxt       = kind_r;
    owner_nxt      = owner_r;
    size_nxt       = size_r;
    res_status_nxt = res_status_r;
    res_base_nxt   = res_base_r;
    res_moved_nxt  = res_moved_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_base_nxt   = out_base_r;
    out_free_nxt   = out_free_r;
    out_moved_nxt  = out_moved_r;
    in_ready       = 1'b0;
    mem_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt  = in_req_type;
          owner_nxt = in_proc_id;
          size_nxt  = in_req_size;
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_status_nxt = ST_OK;
        res_base_nxt   = '0;
        res_moved_nxt  = 1'b0;
        state_nxt      = S_RESULT;
        priority if (kind_r == REQ_ALLOC) begin
          priority if (count_r == CNT_W'(MAX_SEGMENTS)) begin
            res_status_nxt = ST_FULL;
          end else if (size_r > space_w) begin
            res_status_nxt = ST_NO_SPACE;
          end else begin
            mem_req.we           = 1'b1;
            mem_req.waddr        = count_r[IDX_W-1:0];
            mem_req.wdata.owner  = owner_r;
            mem_req.wdata.length = size_r;
            res_base_nxt         = used_r;
            count_nxt            = count_r + CNT_W'(1);
            used_nxt             = used_r + size_r;
          end
        end else if (kind_r == REQ_FREE) begin
          if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = '0;
            idx_nxt       = '0;
            acc_nxt       = '0;
            state_nxt     = S_SEARCH;
          end
        end else if (kind_r == REQ_CLEAR) begin
          count_nxt = '0;
          used_nxt  = '0;
        end else begin
          res_status_nxt = ST_OK;
        end
      end

      S_SEARCH: begin
        if (mem_rdata.owner == owner_r) begin
          res_base_nxt  = acc_r;
          res_moved_nxt = (idx_p1_w < (CNT_W + 1)'(count_r)) && (mem_rdata.length != '0);
          count_nxt     = count_r - CNT_W'(1);
          used_nxt      = used_r - mem_rdata.length;
          if (idx_p1_w < (CNT_W + 1)'(count_r)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = IDX_W'(idx_p1_w);
            state_nxt     = S_SHIFT;
          end else begin
            state_nxt = S_RESULT;
          end
        end else begin
          acc_nxt = acc_r + mem_rdata.length;
          if (idx_p1_w < (CNT_W + 1)'(count_r)) begin
            idx_nxt       = IDX_W'(idx_p1_w);
            mem_req.re    = 1'b1;
            mem_req.raddr = IDX_W'(idx_p1_w);
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            res_base_nxt   = '0;
            state_nxt      = S_RESULT;
          end
        end
      end

      S_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = mem_rdata;
        if (idx_p1_w < (CNT_W + 1)'(count_r)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = IDX_W'(idx_p2_w);
          idx_nxt       = IDX_W'(idx_p1_w);
        end else begin
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_base_nxt   = res_base_r;
          out_free_nxt   = space_w;
          out_moved_nxt  = res_moved_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_base_addr  = out_base_r;
  assign out_free_space = out_free_r;
  assign out_compacted  = out_moved_r;

endmodule

// ===== rtl/compacting_segment_allocator_top.sv =====
// Top level of the compacting segment allocator: sequencer plus segment table memory.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    in_req_type, in_proc_id, in_req_size
//   out_      output     out_valid/out_ready  out_status, out_base_addr,
//                                             out_free_space, out_compacted
//   cfg_      input      cfg_we               cfg_wdata (total size)
//
// An allocate, clear or unknown request, or a free of an empty table, goes from S_DISPATCH
// straight to S_RESULT. A free of a nonempty table first walks S_SEARCH up to the owner's
// entry and, if it finds it with entries behind it, S_SHIFT over those entries. The input is
// held until S_RESULT hands the result to the output register. The table memory has one read port, so
// the owner search and the compaction shift visit one entry per cycle.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
// A new request is taken while a result still waits; a stalled output holds the next
// result in the sequencer until the output register frees.
module compacting_segment_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_proc_id,
  input  logic [15:0] in_req_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_base_addr,
  output logic [15:0] out_free_space,
  output logic        out_compacted,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  import csa_pkg::*;

  mem_req_t   mem_req;
  seg_entry_t mem_rdata;

  csa_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_proc_id     (in_proc_id),
    .in_req_size    (in_req_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_base_addr  (out_base_addr),
    .out_free_space (out_free_space),
    .out_compacted  (out_compacted),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata)
  );

  csa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

`ifndef NO_ASSERTIONS
  a_no_rw_collision : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("Table read and write hit the same entry in one cycle.");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("A new request was taken while one was in progress.");

  a_result_frees_input : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("A result was produced but the sequencer did not return to idle.");
`endif

endmodule
